// ===== rtl/text_console_writer_unit_macros.svh =====
// Assertion helpers for the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define TCW_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field widths fixed by the interface
  localparam int POS_W  = 11;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;
  localparam int CELL_W = 2 * BYTE_W;

  localparam int COL_W = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BACK  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0f;

endpackage
`default_nettype wire

// ===== rtl/text_console_writer_unit.sv =====
// Channel   Signals                                        Moves
// in        in_valid / in_stall, operation, char_code,     one command word
//           cell_index
// out       out_valid / out_stall, cursor_pos, cell_char,  one result word
//           cell_attr
// cfg       cfg_write, cfg_data                            attribute byte
//
// Write, newline, backspace and read pass from accept through ST_DONE to the
// output register. A scroll adds a row move then a bottom-row fill, and a
// clear adds a full-screen fill; both run through the single screen RAM.
// After rst a pass zeroes the screen RAM; in_stall is high during that
// pass. A result waits in the output register under out_stall, and the next
// command is taken meanwhile.
`default_nettype none
module text_console_writer_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [tcw_pkg::BYTE_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [tcw_pkg::OP_W-1:0]   operation,
  input  wire logic [tcw_pkg::BYTE_W-1:0] char_code,
  input  wire logic [tcw_pkg::POS_W-1:0]  cell_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [tcw_pkg::POS_W-1:0]       cursor_pos,
  output logic [tcw_pkg::BYTE_W-1:0]      cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]      cell_attr
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  localparam int PW = tcw_pkg::POS_W;
  localparam int BW = tcw_pkg::BYTE_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;

  localparam logic [PW-1:0] LAST_CELL  = PW'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [PW-1:0] BOTTOM_ROW = PW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
  localparam logic [CW-1:0] LAST_COL   = CW'(tcw_pkg::COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(tcw_pkg::ROWS - 1);

  state_t                          state;
  logic [PW-1:0]                   cursor;
  logic [CW-1:0]                   col;
  logic [RW-1:0]                   row;
  logic [BW-1:0]                   attr;
  logic [PW-1:0]                   scan;
  logic [PW-1:0]                   wptr;
  logic                            pend;
  logic                            fill_blank;
  logic                            op_read;
  logic                            rd_ok;

  logic [tcw_pkg::CELL_W-1:0]      mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0]      rd_data;

  logic                            accept;
  logic                            in_range;
  logic                            out_free;
  logic                            mem_we;
  logic [PW-1:0]                   mem_wa;
  logic [tcw_pkg::CELL_W-1:0]      mem_wd;
  logic                            rd_en;
  logic [PW-1:0]                   rd_addr;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign in_range = (cell_index < PW'(tcw_pkg::CELL_COUNT));
  assign out_free = !out_valid || !out_stall;

  // screen RAM port control
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = scan;
    mem_wd  = '0;
    rd_en   = 1'b0;
    rd_addr = scan;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            tcw_pkg::OP_WRITE: begin
              if (char_code != tcw_pkg::NEWLINE_CODE) begin
                mem_we = 1'b1;
                mem_wa = cursor;
                mem_wd = {attr, char_code};
              end
            end
            tcw_pkg::OP_BACK: begin
              if (cursor != '0) begin
                mem_we = 1'b1;
                mem_wa = cursor - PW'(1);
                mem_wd = {attr, tcw_pkg::SPACE_CODE};
              end
            end
            tcw_pkg::OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = in_range ? cell_index : '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOVE: begin
        // read one row ahead, write the word read last cycle
        rd_en   = 1'b1;
        rd_addr = scan;
        mem_we  = pend;
        mem_wa  = wptr;
        mem_wd  = rd_data;
      end
      ST_DRAIN: begin
        mem_we = 1'b1;
        mem_wa = wptr;
        mem_wd = rd_data;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = scan;
        mem_wd = fill_blank ? {attr, tcw_pkg::SPACE_CODE} : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      cursor     <= '0;
      col        <= '0;
      row        <= '0;
      attr       <= tcw_pkg::ATTR_RESET;
      scan       <= '0;
      wptr       <= '0;
      pend       <= 1'b0;
      fill_blank <= 1'b0;
      op_read    <= 1'b0;
      rd_ok      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_read <= (operation == tcw_pkg::OP_READ);
            rd_ok   <= in_range;
            state   <= ST_DONE;
            case (operation)
              tcw_pkg::OP_WRITE: begin
                if (char_code == tcw_pkg::NEWLINE_CODE || col == LAST_COL) begin
                  if (row == LAST_ROW) begin
                    cursor <= BOTTOM_ROW;
                    col    <= '0;
                    scan   <= PW'(tcw_pkg::COLUMNS);
                    wptr   <= '0;
                    pend   <= 1'b0;
                    state  <= ST_MOVE;
                  end else begin
                    cursor <= cursor + PW'(tcw_pkg::COLUMNS) - PW'(col);
                    col    <= '0;
                    row    <= row + RW'(1);
                  end
                end else begin
                  cursor <= cursor + PW'(1);
                  col    <= col + CW'(1);
                end
              end
              tcw_pkg::OP_CLEAR: begin
                cursor     <= '0;
                col        <= '0;
                row        <= '0;
                scan       <= '0;
                fill_blank <= 1'b1;
                state      <= ST_FILL;
              end
              tcw_pkg::OP_BACK: begin
                if (cursor != '0) begin
                  cursor <= cursor - PW'(1);
                  if (col == '0) begin
                    col <= LAST_COL;
                    row <= row - RW'(1);
                  end else begin
                    col <= col - CW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MOVE: begin
          pend <= 1'b1;
          if (pend) begin
            wptr <= wptr + PW'(1);
          end
          if (scan == LAST_CELL) begin
            state <= ST_DRAIN;
          end else begin
            scan <= scan + PW'(1);
          end
        end
        ST_DRAIN: begin
          scan       <= BOTTOM_ROW;
          fill_blank <= 1'b1;
          state      <= ST_FILL;
        end
        ST_FILL: begin
          if (scan == LAST_CELL) begin
            // the power-up pass (zero fill) returns without a result
            state <= fill_blank ? ST_DONE : ST_IDLE;
          end else begin
            scan <= scan + PW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            cursor_pos <= cursor;
            cell_char  <= (op_read && rd_ok) ? rd_data[BW-1:0] : '0;
            cell_attr  <= (op_read && rd_ok) ? rd_data[2*BW-1:BW] : '0;
            op_read    <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`default_nettype none
`include "text_console_writer_unit_macros.svh"
module tcw_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [tcw_pkg::POS_W-1:0]  cursor_pos,
  input wire logic [tcw_pkg::BYTE_W-1:0] cell_char,
  input wire logic [tcw_pkg::BYTE_W-1:0] cell_attr
);

  localparam int PW = tcw_pkg::POS_W;
  localparam logic [PW-1:0] CELLS = PW'(tcw_pkg::CELL_COUNT);

  // a held result word keeps its payload
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cursor_pos) && $stable(cell_char) && $stable(cell_attr), "result word changed under stall")

  // cursor never leaves the screen
  `TCW_ASSERT_SAME(a_cursor_range, clk, rst, out_valid, cursor_pos < CELLS, "cursor beyond last cell")

  // one command at a time: busy right after an accept
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "second command taken back to back")

  // reset starts the RAM clearing pass with no result pending
  `TCW_ASSERT_ALWAYS(a_reset_clear, clk, rst, in_stall && !out_valid, "reset did not start clearing pass")

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);
`default_nettype wire
